// ===== sv/psrl_pkg.sv =====
// Shared types and codes for the priority scheduler with resource locks.
// Used by psrl_front, psrl_back and the top level; depends on nothing.
package psrl_pkg;

  localparam logic [2:0] OP_CREATE_PROC = 3'd0;
  localparam logic [2:0] OP_CREATE_RES  = 3'd1;
  localparam logic [2:0] OP_DELETE_PROC = 3'd2;
  localparam logic [2:0] OP_DELETE_RES  = 3'd3;
  localparam logic [2:0] OP_TICK        = 3'd4;

  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_ID_IN_USE   = 3'd1;
  localparam logic [2:0] STAT_NO_RES      = 3'd2;
  localparam logic [2:0] STAT_RUNNING     = 3'd3;
  localparam logic [2:0] STAT_RES_IN_USE  = 3'd4;
  localparam logic [2:0] STAT_NO_PROC     = 3'd5;
  localparam logic [2:0] STAT_NONE_READY  = 3'd6;
  localparam logic [2:0] STAT_STEP_ERROR  = 3'd7;

  localparam logic [1:0] SS_READY   = 2'd0;
  localparam logic [1:0] SS_BLOCKED = 2'd1;
  localparam logic [1:0] SS_RUNNING = 2'd2;

  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] steps;
    logic [7:0]  priority_req;
    logic [2:0]  resource_id;
    logic [3:0]  process_id;
    logic [2:0]  operation;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

// ===== sv/psrl_front.sv =====
// Front end: accepts input words and holds them in a two-entry queue.
// Depends on psrl_pkg for the item type.
module psrl_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psrl_pkg::item_t      in_item_i,
  output psrl_pkg::queue_out_t q_out_o,
  input  logic                 q_ready_i
);

  psrl_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push, pop;

  assign in_ready_o    = (count_q != 2'd2);
  assign push          = in_valid_i && in_ready_o;
  assign pop           = q_out_o.valid && q_ready_i;
  assign q_out_o.valid = (count_q != 2'd0);
  assign q_out_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// ===== sv/psrl_back.sv =====
// Back end: process and resource tables, the slot-scanning sequencer and the
// result register. Depends on psrl_pkg for codes and the item type.
module psrl_back #(
  parameter int PROCESS_SLOTS  = 16,
  parameter int RESOURCE_COUNT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psrl_pkg::queue_out_t q_in_i,
  output logic                 q_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          out_data_o
);

  localparam int SW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int RW = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(PROCESS_SLOTS - 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_FINISH, S_DONE} state_e;

  state_e state_q, state_d;
  psrl_pkg::item_t item_q, item_d;

  logic [PROCESS_SLOTS-1:0] valid_q, valid_d;
  logic [7:0]  pri_q   [PROCESS_SLOTS], pri_d   [PROCESS_SLOTS];
  logic [15:0] steps_q [PROCESS_SLOTS], steps_d [PROCESS_SLOTS];
  logic [15:0] wait_q  [PROCESS_SLOTS], wait_d  [PROCESS_SLOTS];
  logic [2:0]  res_q   [PROCESS_SLOTS], res_d   [PROCESS_SLOTS];
  logic [1:0]  sst_q   [PROCESS_SLOTS], sst_d   [PROCESS_SLOTS];

  logic [RESOURCE_COUNT-1:0] exists_q, exists_d, locked_q, locked_d;

  logic          busy_q, busy_d;
  logic [SW-1:0] cpu_q, cpu_d;
  logic [15:0]   cpu_steps_q, cpu_steps_d;
  logic [2:0]    cpu_res_q, cpu_res_d;

  logic [SW-1:0] cnt_q, cnt_d;
  logic          found_q, found_d, hit_q, hit_d;
  logic [SW-1:0] b_idx_q, b_idx_d;
  logic [7:0]    b_pri_q, b_pri_d;
  logic [15:0]   b_wait_q, b_wait_d, b_steps_q, b_steps_d;
  logic [2:0]    b_res_q, b_res_d;
  logic [2:0]    stat_q, stat_d;
  logic          fin_q, fin_d;

  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_data_q, out_data_d;

  logic          pid_ok, rid_ok;
  logic [SW-1:0] pidx;
  logic [RW-1:0] ridx;

  assign pid_ok = (32'(item_q.process_id) < PROCESS_SLOTS);
  assign rid_ok = (32'(item_q.resource_id) < RESOURCE_COUNT);
  assign pidx   = SW'(item_q.process_id);
  assign ridx   = RW'(item_q.resource_id);

  assign q_ready_o   = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    valid_d     = valid_q;
    pri_d       = pri_q;
    steps_d     = steps_q;
    wait_d      = wait_q;
    res_d       = res_q;
    sst_d       = sst_q;
    exists_d    = exists_q;
    locked_d    = locked_q;
    busy_d      = busy_q;
    cpu_d       = cpu_q;
    cpu_steps_d = cpu_steps_q;
    cpu_res_d   = cpu_res_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    hit_d       = hit_q;
    b_idx_d     = b_idx_q;
    b_pri_d     = b_pri_q;
    b_wait_d    = b_wait_q;
    b_steps_d   = b_steps_q;
    b_res_d     = b_res_q;
    stat_d      = stat_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (q_in_i.valid) begin
          item_d  = q_in_i.item;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        stat_d  = psrl_pkg::STAT_OK;
        fin_d   = 1'b0;
        cnt_d   = '0;
        found_d = 1'b0;
        hit_d   = 1'b0;
        state_d = S_DONE;
        case (item_q.operation)
          psrl_pkg::OP_CREATE_PROC: begin
            if (!pid_ok || valid_q[pidx]) begin
              stat_d = psrl_pkg::STAT_ID_IN_USE;
            end else if (!rid_ok || !exists_q[ridx]) begin
              stat_d = psrl_pkg::STAT_NO_RES;
            end else begin
              valid_d[pidx] = 1'b1;
              pri_d[pidx]   = item_q.priority_req;
              steps_d[pidx] = item_q.steps;
              wait_d[pidx]  = '0;
              res_d[pidx]   = item_q.resource_id;
              sst_d[pidx]   = locked_q[ridx] ? psrl_pkg::SS_BLOCKED : psrl_pkg::SS_READY;
            end
          end
          psrl_pkg::OP_CREATE_RES: begin
            if (!rid_ok || exists_q[ridx]) begin
              stat_d = psrl_pkg::STAT_ID_IN_USE;
            end else begin
              exists_d[ridx] = 1'b1;
              locked_d[ridx] = 1'b0;
            end
          end
          psrl_pkg::OP_DELETE_PROC: begin
            if (!pid_ok || !valid_q[pidx]) begin
              stat_d = psrl_pkg::STAT_NO_PROC;
            end else if (busy_q && cpu_q == pidx) begin
              stat_d = psrl_pkg::STAT_RUNNING;
            end else begin
              valid_d[pidx] = 1'b0;
            end
          end
          psrl_pkg::OP_DELETE_RES: begin
            state_d = S_SCAN;
          end
          psrl_pkg::OP_TICK: begin
            // End the running turn: free its resource and wake its waiters.
            if (busy_q && valid_q[cpu_q]) begin
              if (cpu_steps_q == 16'd0) begin
                valid_d[cpu_q] = 1'b0;
                fin_d          = 1'b1;
              end
              if (32'(cpu_res_q) < RESOURCE_COUNT) begin
                locked_d[RW'(cpu_res_q)] = 1'b0;
              end
              for (int i = 0; i < PROCESS_SLOTS; i++) begin
                if (valid_q[i] && res_q[i] == cpu_res_q) begin
                  sst_d[i] = psrl_pkg::SS_READY;
                end
              end
            end
            busy_d  = 1'b0;
            cpu_d   = '0;
            state_d = S_SCAN;
          end
          default: begin
            stat_d = psrl_pkg::STAT_OK;
          end
        endcase
      end
      S_SCAN: begin
        if (item_q.operation == psrl_pkg::OP_DELETE_RES) begin
          if (valid_q[cnt_q] && res_q[cnt_q] == item_q.resource_id) begin
            hit_d = 1'b1;
          end
        end else if (valid_q[cnt_q] && sst_q[cnt_q] == psrl_pkg::SS_READY) begin
          if (!found_q || pri_q[cnt_q] > b_pri_q ||
              (pri_q[cnt_q] == b_pri_q && wait_q[cnt_q] > b_wait_q)) begin
            found_d   = 1'b1;
            b_idx_d   = cnt_q;
            b_pri_d   = pri_q[cnt_q];
            b_wait_d  = wait_q[cnt_q];
            b_steps_d = steps_q[cnt_q];
            b_res_d   = res_q[cnt_q];
          end
        end
        if (cnt_q == LAST_SLOT) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FINISH: begin
        state_d = S_DONE;
        if (item_q.operation == psrl_pkg::OP_DELETE_RES) begin
          if (hit_q) begin
            stat_d = psrl_pkg::STAT_RES_IN_USE;
          end else if (!rid_ok || !exists_q[ridx]) begin
            stat_d = psrl_pkg::STAT_NO_RES;
          end else begin
            exists_d[ridx] = 1'b0;
            locked_d[ridx] = 1'b0;
          end
        end else if (!found_q) begin
          stat_d = psrl_pkg::STAT_NONE_READY;
        end else if (b_steps_q == 16'd0) begin
          stat_d = psrl_pkg::STAT_STEP_ERROR;
        end else begin
          if (32'(b_res_q) < RESOURCE_COUNT) begin
            locked_d[RW'(b_res_q)] = 1'b1;
          end
          // Lock out the other ready processes that share the winner's resource,
          // and age everyone but the winner.
          for (int i = 0; i < PROCESS_SLOTS; i++) begin
            if (valid_q[i] && sst_q[i] == psrl_pkg::SS_READY && res_q[i] == b_res_q) begin
              sst_d[i] = psrl_pkg::SS_BLOCKED;
            end
            if (valid_q[i] && SW'(i) != b_idx_q && wait_q[i] != psrl_pkg::WAIT_MAX) begin
              wait_d[i] = wait_q[i] + 16'd1;
            end
          end
          steps_d[b_idx_q] = b_steps_q - 16'd1;
          sst_d[b_idx_q]   = psrl_pkg::SS_RUNNING;
          wait_d[b_idx_q]  = '0;
          busy_d           = 1'b1;
          cpu_d            = b_idx_q;
          cpu_steps_d      = b_steps_q - 16'd1;
          cpu_res_d        = b_res_q;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'd0, fin_q,
                         busy_q ? cpu_steps_q : 16'd0,
                         busy_q ? 4'(cpu_q) : 4'd0,
                         busy_q, stat_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      exists_q    <= '0;
      locked_q    <= '0;
      busy_q      <= 1'b0;
      cpu_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      exists_q    <= exists_d;
      locked_q    <= locked_d;
      busy_q      <= busy_d;
      cpu_q       <= cpu_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    pri_q       <= pri_d;
    steps_q     <= steps_d;
    wait_q      <= wait_d;
    res_q       <= res_d;
    sst_q       <= sst_d;
    cpu_steps_q <= cpu_steps_d;
    cpu_res_q   <= cpu_res_d;
    b_idx_q     <= b_idx_d;
    b_pri_q     <= b_pri_d;
    b_wait_q    <= b_wait_d;
    b_steps_q   <= b_steps_d;
    b_res_q     <= b_res_d;
    stat_q      <= stat_d;
    fin_q       <= fin_d;
    out_data_q  <= out_data_d;
  end

endmodule

// ===== sv/priority_scheduler_with_resource_locks.sv =====
// Top level of the priority scheduler with resource locks.
// Instantiates psrl_front and psrl_back; uses psrl_pkg for the item type.
//
//   channel   direction  word                              handshake
//   s_axis    in         operation in tuser, rest 32 bits  s_axis_tvalid_i / s_axis_tready_o
//   m_axis    out        one result, 32 bits               m_axis_tvalid_o / m_axis_tready_i
//
// With the back end idle, a tick or a resource delete goes through S_EXEC, the sequencer
// that walks the process slots one per cycle, S_FINISH and S_DONE before its result is
// registered; the other operations go from S_EXEC straight to S_DONE.
// Reset clears the slot and resource valid bits and the running marker at once.
// A held result parks the back end in its last state; the two-word input queue keeps
// accepting until it is full, and only then does s_axis_tready_o drop.
module priority_scheduler_with_resource_locks #(
  parameter int PROCESS_SLOTS  = 16,
  parameter int RESOURCE_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] process_id, [6:4] resource_id, [14:7] priority_req,
  // [30:15] steps, [31] zero
  input  logic [31:0] s_axis_tdata_i,
  // [2:0] operation
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] status, [3] running_valid, [7:4] running_process,
  // [23:8] steps_left, [24] finished, [31:25] zero
  output logic [31:0] m_axis_tdata_o
);

  psrl_pkg::item_t      in_item;
  psrl_pkg::queue_out_t q_out;
  logic                 q_ready;

  assign in_item = psrl_pkg::item_t'({s_axis_tdata_i[30:0], s_axis_tuser_i});

  psrl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .q_out_o    (q_out),
    .q_ready_i  (q_ready)
  );

  psrl_back #(
    .PROCESS_SLOTS  (PROCESS_SLOTS),
    .RESOURCE_COUNT (RESOURCE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_in_i      (q_out),
    .q_ready_o   (q_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
